// ===== design/mraf_pkg.sv =====
`default_nettype none

package mraf_pkg;

  localparam int unsigned AddrWidth   = 48;
  localparam int unsigned TableWords  = 128;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned WordAw      = $clog2(TableWords);
  localparam int unsigned BitAw       = $clog2(WordBits);
  localparam int unsigned HashWidth   = WordAw + BitAw;
  localparam int unsigned HashLsb     = AddrWidth - HashWidth;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [2:0] KIND_REJECT        = 3'd0;
  localparam logic [2:0] KIND_EXACT         = 3'd1;
  localparam logic [2:0] KIND_UNI_PROMISC   = 3'd2;
  localparam logic [2:0] KIND_BROADCAST     = 3'd3;
  localparam logic [2:0] KIND_MULTI_PROMISC = 3'd4;
  localparam logic [2:0] KIND_HASH_HIT      = 3'd5;
  localparam logic [2:0] KIND_ADD           = 3'd6;

  localparam logic [CfgIdxWidth-1:0] REG_STATION_ADDRESS    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_STATION_VALID      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_BROADCAST_ACCEPT   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_UNICAST_PROMISC    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_MULTICAST_PROMISC  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_HASH_FILTER_ENABLE = 3'd5;

  typedef struct packed {
    logic                 opcode;
    logic [AddrWidth-1:0] dest_address;
    logic                 set_enable;
  } in_item_t;

  typedef struct packed {
    logic                 accept;
    logic [2:0]           match_kind;
    logic [HashWidth-1:0] hash_index;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic exec_go;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/mraf_ram.sv =====
`default_nettype none

module mraf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/mraf_ctrl.sv =====
`default_nettype none

module mraf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire mraf_pkg::dp_status_t status_i,
  output mraf_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec_go = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mraf_dp.sv =====
`default_nettype none

module mraf_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire mraf_pkg::in_item_t                   in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output mraf_pkg::out_item_t                       out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [mraf_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [mraf_pkg::AddrWidth-1:0]       cfg_data_i,
  input  wire mraf_pkg::dp_cmd_t                    cmd_i,
  output mraf_pkg::dp_status_t                      status_o
);

  logic [mraf_pkg::AddrWidth-1:0] station_address_q;
  logic                           station_valid_q;
  logic                           broadcast_accept_q;
  logic                           unicast_promisc_q;
  logic                           multicast_promisc_q;
  logic                           hash_filter_enable_q;

  mraf_pkg::in_item_t             item_q;
  logic [mraf_pkg::TableWords-1:0] word_valid_q;
  mraf_pkg::out_item_t            out_q;
  logic                           out_valid_q;

  logic [mraf_pkg::HashWidth-1:0] hash;
  logic [mraf_pkg::WordAw-1:0]    word_idx;
  logic [mraf_pkg::BitAw-1:0]     bit_idx;
  logic [mraf_pkg::WordAw-1:0]    rd_idx;
  logic [mraf_pkg::WordBits-1:0]  rdata;
  logic [mraf_pkg::WordBits-1:0]  word;
  logic [mraf_pkg::WordBits-1:0]  wdata;
  logic                           wr_en;
  logic                           hit;
  logic                           multi;
  logic                           bcast;
  logic [2:0]                     kind;
  mraf_pkg::out_item_t            result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_address_q    <= '0;
      station_valid_q      <= 1'b0;
      broadcast_accept_q   <= 1'b0;
      unicast_promisc_q    <= 1'b0;
      multicast_promisc_q  <= 1'b0;
      hash_filter_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mraf_pkg::REG_STATION_ADDRESS:    station_address_q    <= cfg_data_i;
        mraf_pkg::REG_STATION_VALID:      station_valid_q      <= cfg_data_i[0];
        mraf_pkg::REG_BROADCAST_ACCEPT:   broadcast_accept_q   <= cfg_data_i[0];
        mraf_pkg::REG_UNICAST_PROMISC:    unicast_promisc_q    <= cfg_data_i[0];
        mraf_pkg::REG_MULTICAST_PROMISC:  multicast_promisc_q  <= cfg_data_i[0];
        mraf_pkg::REG_HASH_FILTER_ENABLE: hash_filter_enable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
  end

  assign rd_idx   = in_data_i.dest_address[mraf_pkg::AddrWidth-1 -: mraf_pkg::WordAw];
  assign hash     = item_q.dest_address[mraf_pkg::AddrWidth-1 -: mraf_pkg::HashWidth];
  assign word_idx = hash[mraf_pkg::HashWidth-1 -: mraf_pkg::WordAw];
  assign bit_idx  = hash[mraf_pkg::BitAw-1:0];

  mraf_ram #(
    .Width (mraf_pkg::WordBits),
    .Depth (mraf_pkg::TableWords)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (word_idx),
    .wdata_i (wdata),
    .re_i    (cmd_i.load_item),
    .raddr_i (rd_idx),
    .rdata_o (rdata)
  );

  // A word that was never written reads as zero, which stands in for the reset clear.
  assign word  = word_valid_q[word_idx] ? rdata : '0;
  assign hit   = word[bit_idx];
  assign wdata = word | (mraf_pkg::WordBits'(1) << bit_idx);
  assign wr_en = cmd_i.exec_go && (item_q.opcode == mraf_pkg::OP_ADD) && item_q.set_enable;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= '0;
    end else if (wr_en) begin
      word_valid_q[word_idx] <= 1'b1;
    end
  end

  assign multi = item_q.dest_address[0];
  assign bcast = &item_q.dest_address;

  always_comb begin
    if (item_q.opcode == mraf_pkg::OP_ADD) begin
      kind = mraf_pkg::KIND_ADD;
    end else if (station_valid_q && (item_q.dest_address == station_address_q)) begin
      kind = mraf_pkg::KIND_EXACT;
    end else if (!multi && unicast_promisc_q) begin
      kind = mraf_pkg::KIND_UNI_PROMISC;
    end else if (bcast && broadcast_accept_q) begin
      kind = mraf_pkg::KIND_BROADCAST;
    end else if (multi && !bcast && multicast_promisc_q) begin
      kind = mraf_pkg::KIND_MULTI_PROMISC;
    end else if (multi && !bcast && hash_filter_enable_q && hit) begin
      kind = mraf_pkg::KIND_HASH_HIT;
    end else begin
      kind = mraf_pkg::KIND_REJECT;
    end
  end

  assign result.accept     = (kind != mraf_pkg::KIND_REJECT) && (kind != mraf_pkg::KIND_ADD);
  assign result.match_kind = kind;
  assign result.hash_index = hash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_go) begin
      out_q <= result;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

// ===== design/mac_receive_address_filter.sv =====
// Channel   Direction  Payload               Handshake
// in        input      mraf_pkg::in_item_t   in_valid_i / in_stall_o
// out       output     mraf_pkg::out_item_t  out_valid_o / out_stall_i
// cfg       input      index + 48-bit data   cfg_we_i, no wait
//
// For each item, the transfer cycle reads the hash table word; once the output register
// is free, the item is classified or the word is written back, and the output register is loaded.
// The registered read of the table memory makes these separate steps.
// Reset clears the control state, the configuration registers, the output valid
// and the valid bit of every table word at once.
// A pending result in the output register does not hold off the next input
// transfer; only a second result waiting behind a stalled one does.
`default_nettype none

module mac_receive_address_filter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire mraf_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output mraf_pkg::out_item_t                   out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [mraf_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [mraf_pkg::AddrWidth-1:0]   cfg_data_i
);

  mraf_pkg::dp_cmd_t    cmd;
  mraf_pkg::dp_status_t status;

  mraf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mraf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

// ===== design/mraf_checker.sv =====
`default_nettype none

module mraf_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire mraf_pkg::out_item_t out_data_o
);

  // One item at a time: the input side closes right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // A new result only follows a cycle in which an item was being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  // Accept follows the kind: set for every accepting rule, clear for reject and add.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.accept ==
      ((out_data_o.match_kind != mraf_pkg::KIND_REJECT) &&
       (out_data_o.match_kind != mraf_pkg::KIND_ADD))))
    else $error("accept flag disagrees with match kind");

endmodule

bind mac_receive_address_filter mraf_checker u_mraf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PoolDepth   = 64;
  localparam int unsigned PhaseFrames = 140;
  localparam int unsigned PhaseCount  = 12;

  localparam logic [mraf_pkg::CfgIdxWidth-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [mraf_pkg::CfgIdxWidth-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [mraf_pkg::AddrWidth-1:0] BroadcastAddr = '1;
  localparam logic [mraf_pkg::AddrWidth-1:0] GroupAddrA    = 48'h4560_0000_0003;
  localparam logic [mraf_pkg::AddrWidth-1:0] GroupAddrB    = 48'h1230_0000_0001;
  localparam logic [mraf_pkg::AddrWidth-1:0] GroupAddrTop  = 48'hFFF0_0000_0001;
  localparam logic [mraf_pkg::AddrWidth-1:0] GroupAddrLow  = 48'h0000_0000_0001;
  localparam logic [mraf_pkg::AddrWidth-1:0] UnicastHigh   = 48'hFFFF_FFFF_FFFE;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic                                 clk       = 1'b0;
  logic                                 rst_n     = 1'b0;
  logic                                 in_valid  = 1'b0;
  logic                                 in_stall;
  mraf_pkg::in_item_t                   in_data   = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  mraf_pkg::out_item_t                  out_data;
  logic                                 cfg_we    = 1'b0;
  logic [mraf_pkg::CfgIdxWidth-1:0]     cfg_index = '0;
  logic [mraf_pkg::AddrWidth-1:0]       cfg_data  = '0;

  logic [mraf_pkg::WordBits-1:0]  hash_words [mraf_pkg::TableWords];
  logic [mraf_pkg::AddrWidth-1:0] own_address      = '0;
  logic                           own_valid        = 1'b0;
  logic                           bcast_on         = 1'b0;
  logic                           uni_promisc_on   = 1'b0;
  logic                           multi_promisc_on = 1'b0;
  logic                           hash_on          = 1'b0;

  mraf_pkg::in_item_t             pending_frames [$];
  mraf_pkg::out_item_t            expected_verdicts [$];
  logic [mraf_pkg::AddrWidth-1:0] added_pool [$];

  logic        in_taken       = 1'b0;
  logic        sender_eager   = 1'b0;
  logic        hold_request   = 1'b0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  int unsigned mode_left      = 0;
  stall_mode_e stall_mode     = STALL_NONE;
  int unsigned idle_cycles    = 0;
  int unsigned mismatch_count = 0;

  mac_receive_address_filter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic mraf_pkg::out_item_t filter_decision(mraf_pkg::in_item_t item);
    logic [mraf_pkg::HashWidth-1:0] hv;
    logic [mraf_pkg::WordAw-1:0]    word_sel;
    logic [mraf_pkg::BitAw-1:0]     bit_sel;
    logic                           is_group;
    logic                           is_bcast;
    mraf_pkg::out_item_t            r;
    hv       = item.dest_address[mraf_pkg::AddrWidth-1 -: mraf_pkg::HashWidth];
    word_sel = hv[mraf_pkg::HashWidth-1 -: mraf_pkg::WordAw];
    bit_sel  = hv[mraf_pkg::BitAw-1:0];
    is_group = item.dest_address[0];
    is_bcast = item.dest_address == BroadcastAddr;
    r.hash_index = hv;
    if (item.opcode == mraf_pkg::OP_ADD) begin
      if (item.set_enable) begin
        hash_words[word_sel][bit_sel] = 1'b1;
      end
      r.match_kind = mraf_pkg::KIND_ADD;
    end else if (own_valid && item.dest_address == own_address) begin
      r.match_kind = mraf_pkg::KIND_EXACT;
    end else if (!is_group && uni_promisc_on) begin
      r.match_kind = mraf_pkg::KIND_UNI_PROMISC;
    end else if (is_bcast && bcast_on) begin
      r.match_kind = mraf_pkg::KIND_BROADCAST;
    end else if (is_group && !is_bcast && multi_promisc_on) begin
      r.match_kind = mraf_pkg::KIND_MULTI_PROMISC;
    end else if (is_group && !is_bcast && hash_on && hash_words[word_sel][bit_sel]) begin
      r.match_kind = mraf_pkg::KIND_HASH_HIT;
    end else begin
      r.match_kind = mraf_pkg::KIND_REJECT;
    end
    r.accept = item.opcode == mraf_pkg::OP_CLASSIFY && r.match_kind != mraf_pkg::KIND_REJECT;
    return r;
  endfunction

  function automatic logic [mraf_pkg::AddrWidth-1:0] random_address();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[mraf_pkg::AddrWidth-1:0];
  endfunction

  function automatic logic [mraf_pkg::AddrWidth-1:0] flag_word(logic b);
    logic [mraf_pkg::AddrWidth-1:0] w;
    w    = $urandom_range(0, 1) ? random_address() : '0;
    w[0] = b;
    return w;
  endfunction

  function automatic mraf_pkg::in_item_t random_frame();
    mraf_pkg::in_item_t             f;
    logic [mraf_pkg::AddrWidth-1:0] a;
    int unsigned                    pick;
    int unsigned                    slot;
    pick = $urandom_range(0, 99);
    a    = random_address();
    slot = added_pool.size() == 0 ? 0 : $urandom_range(0, added_pool.size() - 1);
    f.opcode     = $urandom_range(0, 99) < 35 ? mraf_pkg::OP_ADD : mraf_pkg::OP_CLASSIFY;
    f.set_enable = $urandom_range(0, 3) != 0;
    if (pick < 20 && added_pool.size() != 0) begin
      a = added_pool[slot];
    end else if (pick < 32 && added_pool.size() != 0) begin
      a[mraf_pkg::AddrWidth-1 -: mraf_pkg::HashWidth] =
          added_pool[slot][mraf_pkg::AddrWidth-1 -: mraf_pkg::HashWidth];
      a[0] = 1'b1;
    end else if (pick < 40) begin
      a = own_address;
    end else if (pick < 47) begin
      a = BroadcastAddr;
    end else if (pick < 50) begin
      a = '0;
    end else if (pick < 75) begin
      a[0] = 1'b1;
    end
    if (f.opcode == mraf_pkg::OP_ADD) begin
      added_pool.push_back(a);
      if (added_pool.size() > PoolDepth) begin
        void'(added_pool.pop_front());
      end
    end
    f.dest_address = a;
    return f;
  endfunction

  task automatic push_frame(logic op, logic [mraf_pkg::AddrWidth-1:0] a, logic set_en);
    mraf_pkg::in_item_t f;
    f.opcode       = op;
    f.dest_address = a;
    f.set_enable   = set_en;
    pending_frames.push_back(f);
  endtask

  task automatic write_filter_reg(logic [mraf_pkg::CfgIdxWidth-1:0] idx,
                                  logic [mraf_pkg::AddrWidth-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mraf_pkg::REG_STATION_ADDRESS:    own_address      = value;
      mraf_pkg::REG_STATION_VALID:      own_valid        = value[0];
      mraf_pkg::REG_BROADCAST_ACCEPT:   bcast_on         = value[0];
      mraf_pkg::REG_UNICAST_PROMISC:    uni_promisc_on   = value[0];
      mraf_pkg::REG_MULTICAST_PROMISC:  multi_promisc_on = value[0];
      mraf_pkg::REG_HASH_FILTER_ENABLE: hash_on          = value[0];
      default: ;
    endcase
  endtask

  task automatic write_flags(logic sv, logic ba, logic up, logic mp, logic he);
    write_filter_reg(mraf_pkg::REG_STATION_VALID, flag_word(sv));
    write_filter_reg(mraf_pkg::REG_BROADCAST_ACCEPT, flag_word(ba));
    write_filter_reg(mraf_pkg::REG_UNICAST_PROMISC, flag_word(up));
    write_filter_reg(mraf_pkg::REG_MULTICAST_PROMISC, flag_word(mp));
    write_filter_reg(mraf_pkg::REG_HASH_FILTER_ENABLE, flag_word(he));
  endtask

  task automatic random_settings();
    logic [mraf_pkg::AddrWidth-1:0] st;
    case ($urandom_range(0, 4))
      0: st = random_address();
      1: st = BroadcastAddr;
      2: st = '0;
      default: st = added_pool.size() != 0 ?
          added_pool[$urandom_range(0, added_pool.size() - 1)] : random_address();
    endcase
    write_filter_reg(mraf_pkg::REG_STATION_ADDRESS, st);
    write_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) == 0) begin
      write_filter_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, random_address());
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_frames.size() != 0 || expected_verdicts.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  always @(negedge clk) begin : sender
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0 && !sender_eager) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_frames.size() != 0) begin
        in_data  <= pending_frames.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= $urandom_range(0, 3) == 0;
        STALL_HEAVY: out_stall <= $urandom_range(0, 3) != 0;
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    mraf_pkg::out_item_t want;
    logic                out_taken;
    if (rst_n) begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (in_taken) begin
        expected_verdicts.push_back(filter_decision(in_data));
      end
      if (out_taken) begin
        if (expected_verdicts.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected none, got accept=%0b kind=%0d hash=%03h", $time,
                   out_data.accept, out_data.match_kind, out_data.hash_index);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.accept !== want.accept || out_data.match_kind !== want.match_kind ||
              out_data.hash_index !== want.hash_index) begin
            mismatch_count++;
            $display("%0t: expected accept=%0b kind=%0d hash=%03h, %s",
                     $time, want.accept, want.match_kind, want.hash_index,
                     $sformatf("got accept=%0b kind=%0d hash=%03h",
                               out_data.accept, out_data.match_kind, out_data.hash_index));
          end
        end
      end
      if (in_taken || out_taken || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    for (int k = 0; k < mraf_pkg::TableWords; k++) begin
      hash_words[k] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: nothing is accepted, adds fill the table.
    push_frame(mraf_pkg::OP_CLASSIFY, '0, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, BroadcastAddr, 1'b1);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrB, 1'b0);
    push_frame(mraf_pkg::OP_ADD, GroupAddrA, 1'b0);
    push_frame(mraf_pkg::OP_ADD, GroupAddrB, 1'b1);
    push_frame(mraf_pkg::OP_ADD, BroadcastAddr, 1'b1);
    push_frame(mraf_pkg::OP_ADD, GroupAddrLow, 1'b1);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrB, 1'b1);
    wait_idle();

    // The station address is all ones, so exact matching wins over broadcast.
    write_filter_reg(mraf_pkg::REG_STATION_ADDRESS, BroadcastAddr);
    write_flags(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    push_frame(mraf_pkg::OP_CLASSIFY, BroadcastAddr, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrB, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrA, 1'b1);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrTop, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, '0, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrLow, 1'b1);
    wait_idle();

    write_filter_reg(mraf_pkg::REG_STATION_ADDRESS, '0);
    write_flags(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    write_filter_reg(REG_SPARE_LO, BroadcastAddr);
    write_filter_reg(REG_SPARE_HI, BroadcastAddr);
    push_frame(mraf_pkg::OP_CLASSIFY, '0, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, BroadcastAddr, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrB, 1'b1);
    push_frame(mraf_pkg::OP_CLASSIFY, UnicastHigh, 1'b0);
    wait_idle();

    // A broadcast destination is never accepted through the hash table.
    write_flags(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    push_frame(mraf_pkg::OP_CLASSIFY, '0, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, BroadcastAddr, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrB, 1'b0);
    push_frame(mraf_pkg::OP_ADD, GroupAddrA, 1'b0);
    push_frame(mraf_pkg::OP_CLASSIFY, GroupAddrA, 1'b0);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering transfers.
    random_settings();
    sender_eager = 1'b1;
    @(posedge clk);
    hold_request = 1'b1;
    repeat (60) pending_frames.push_back(random_frame());
    wait_idle();
    sender_eager = 1'b0;

    for (int p = 0; p < PhaseCount; p++) begin
      random_settings();
      repeat (PhaseFrames) pending_frames.push_back(random_frame());
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mraf_pkg.sv
design/mraf_ram.sv
design/mraf_ctrl.sv
design/mraf_dp.sv
design/mac_receive_address_filter.sv
design/mraf_checker.sv
dv/testbench.sv
